// File: hw/rtl/assert_macros.svh
// Assertion macros for the register transaction sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk_sig, rst_n, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (expr)) \
		else $error("sequencer assertion failed");

`define ASSERT_IMPLIES(lbl, clk_sig, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_sig, rst_n, expr)

`define ASSERT_IMPLIES(lbl, clk_sig, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/i2cseq_pkg.sv
// Types and constants shared by the register transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

	localparam int unsigned MAX_LEN = 32;
	localparam int unsigned BUF_AW  = $clog2(MAX_LEN);

	typedef enum logic [2:0] {
		CMD_LOAD     = 3'd0,
		CMD_BEGIN_RD = 3'd1,
		CMD_BEGIN_WR = 3'd2,
		CMD_START    = 3'd3,
		CMD_XFER     = 3'd4,
		CMD_STOP     = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_REFUSED    = 4'd1,
		ACT_BEGIN      = 4'd2,
		ACT_SEND       = 4'd3,
		ACT_RSTART     = 4'd4,
		ACT_TO_RX      = 4'd5,
		ACT_STORE      = 4'd6,
		ACT_STORE_LAST = 4'd7,
		ACT_STOP       = 4'd8,
		ACT_DONE       = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		PH_ADDR    = 2'd0,
		PH_REG     = 2'd1,
		PH_RXSTART = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [6:0] slave_address;
		logic [7:0] register_address;
		logic [5:0] length;
		logic [7:0] data_byte;
		logic [4:0] load_index;
		logic       ack_received;
		logic       bus_busy;
	} evt_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] tx_byte;
		logic       set_nack;
		logic [4:0] rx_index;
		logic [7:0] rx_byte;
		logic       busy_res;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] idx;
		logic [7:0]        data;
	} wbuf_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2cseq_wbuf.sv
// Write byte buffer with registered read and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_wbuf (
	input  wire logic                              clk,
	input  wire i2cseq_pkg::wbuf_wr_t              wr,
	input  wire logic [i2cseq_pkg::BUF_AW-1:0]     rd_idx,
	output logic [7:0]                             rd_data
);

	logic [7:0] mem [i2cseq_pkg::MAX_LEN];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (wr.en && (wr.idx == rd_idx)) begin
			rd_q <= wr.data;
		end else begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// File: hw/rtl/i2cseq_core.sv
// Transaction state and per-event decision logic.
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire i2cseq_pkg::evt_t              evt,
	input  wire logic [7:0]                    rd_data,
	output i2cseq_pkg::wbuf_wr_t               wr,
	output logic [i2cseq_pkg::BUF_AW-1:0]      rd_idx,
	output i2cseq_pkg::res_t                   res
);

	i2cseq_pkg::phase_t phase_q, phase_d;
	logic               write_mode_q, write_mode_d;
	logic               tx_dir_q, tx_dir_d;
	logic [1:0]         start_cnt_q, start_cnt_d;
	logic [5:0]         position_q, position_d;
	logic [5:0]         byte_cnt_q, byte_cnt_d;
	logic [6:0]         tgt_addr_q, tgt_addr_d;
	logic [7:0]         tgt_reg_q, tgt_reg_d;
	logic               bus_held_q, bus_held_d;
	logic               nack_q, nack_d;

	i2cseq_pkg::action_t act;
	logic                xfer;
	logic [1:0]          start_inc;
	logic                start_cnt_upd;
	logic [6:0]          pos_p1;
	logic [6:0]          pos_p2;
	logic                pos_at_end;

	assign start_inc     = (start_cnt_q != 2'd3) ? start_cnt_q + 2'd1 : start_cnt_q;
	assign start_cnt_upd = (evt.cmd == i2cseq_pkg::CMD_START) && bus_held_q;
	assign pos_p1        = {1'b0, position_q} + 7'd1;
	assign pos_p2        = {1'b0, position_q} + 7'd2;
	assign pos_at_end    = (position_q >= byte_cnt_q) || (32'(position_q) >= i2cseq_pkg::MAX_LEN);

	// decide the action for the held event
	always_comb begin
		act  = i2cseq_pkg::ACT_NONE;
		xfer = 1'b0;
		case (evt.cmd)
			i2cseq_pkg::CMD_BEGIN_RD, i2cseq_pkg::CMD_BEGIN_WR: begin
				if (evt.bus_busy || bus_held_q || (evt.length == 6'd0) ||
				    (32'(evt.length) > i2cseq_pkg::MAX_LEN)) begin
					act = i2cseq_pkg::ACT_REFUSED;
				end else begin
					act = i2cseq_pkg::ACT_BEGIN;
				end
			end
			i2cseq_pkg::CMD_START: begin
				if (bus_held_q) begin
					if (start_inc == 2'd1 || start_inc == 2'd2) begin
						act = i2cseq_pkg::ACT_SEND;
					end else begin
						xfer = 1'b1;
					end
				end
			end
			i2cseq_pkg::CMD_XFER: begin
				xfer = bus_held_q;
			end
			i2cseq_pkg::CMD_STOP: begin
				act = i2cseq_pkg::ACT_DONE;
			end
			default: begin
				act = i2cseq_pkg::ACT_NONE;
			end
		endcase
		if (xfer) begin
			if (tx_dir_q) begin
				if (!evt.ack_received) begin
					act = i2cseq_pkg::ACT_STOP;
				end else if (!write_mode_q) begin
					case (phase_q)
						i2cseq_pkg::PH_ADDR:    act = i2cseq_pkg::ACT_SEND;
						i2cseq_pkg::PH_REG:     act = i2cseq_pkg::ACT_RSTART;
						i2cseq_pkg::PH_RXSTART: act = i2cseq_pkg::ACT_TO_RX;
						default:                act = i2cseq_pkg::ACT_NONE;
					endcase
				end else begin
					case (phase_q)
						i2cseq_pkg::PH_ADDR: act = i2cseq_pkg::ACT_SEND;
						i2cseq_pkg::PH_DATA: act = pos_at_end ? i2cseq_pkg::ACT_STOP
						                                      : i2cseq_pkg::ACT_SEND;
						default:             act = i2cseq_pkg::ACT_NONE;
					endcase
				end
			end else if (phase_q == i2cseq_pkg::PH_DATA) begin
				act = (pos_p1 >= {1'b0, byte_cnt_q}) ? i2cseq_pkg::ACT_STORE_LAST
				                                      : i2cseq_pkg::ACT_STORE;
			end
		end
	end

	// next state
	always_comb begin
		phase_d      = phase_q;
		write_mode_d = write_mode_q;
		tx_dir_d     = tx_dir_q;
		start_cnt_d  = start_cnt_q;
		position_d   = position_q;
		byte_cnt_d   = byte_cnt_q;
		tgt_addr_d   = tgt_addr_q;
		tgt_reg_d    = tgt_reg_q;
		bus_held_d   = bus_held_q;
		nack_d       = nack_q;
		if (start_cnt_upd) begin
			start_cnt_d = start_inc;
		end
		case (act)
			i2cseq_pkg::ACT_BEGIN: begin
				tgt_addr_d   = evt.slave_address;
				tgt_reg_d    = evt.register_address;
				byte_cnt_d   = evt.length;
				write_mode_d = (evt.cmd == i2cseq_pkg::CMD_BEGIN_WR);
				phase_d      = i2cseq_pkg::PH_ADDR;
				position_d   = 6'd0;
				start_cnt_d  = 2'd0;
				tx_dir_d     = 1'b1;
				nack_d       = 1'b0;
				bus_held_d   = 1'b1;
			end
			i2cseq_pkg::ACT_SEND: begin
				if (xfer) begin
					if (phase_q == i2cseq_pkg::PH_ADDR) begin
						phase_d = write_mode_q ? i2cseq_pkg::PH_DATA : i2cseq_pkg::PH_REG;
					end else begin
						position_d = position_q + 6'd1;
					end
				end
			end
			i2cseq_pkg::ACT_RSTART: begin
				phase_d = i2cseq_pkg::PH_RXSTART;
			end
			i2cseq_pkg::ACT_TO_RX: begin
				phase_d  = i2cseq_pkg::PH_DATA;
				tx_dir_d = 1'b0;
				if (byte_cnt_q == 6'd1) begin
					nack_d = 1'b1;
				end
			end
			i2cseq_pkg::ACT_STORE: begin
				position_d = position_q + 6'd1;
				if (pos_p2 == {1'b0, byte_cnt_q}) begin
					nack_d = 1'b1;
				end
			end
			i2cseq_pkg::ACT_STORE_LAST, i2cseq_pkg::ACT_STOP: begin
				bus_held_d = 1'b0;
			end
			i2cseq_pkg::ACT_DONE: begin
				bus_held_d = 1'b0;
				nack_d     = 1'b0;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// result fields
	always_comb begin
		res          = '0;
		res.action   = act;
		res.set_nack = nack_d;
		res.busy_res = bus_held_d;
		case (act)
			i2cseq_pkg::ACT_SEND: begin
				if (!xfer) begin
					res.tx_byte = {tgt_addr_q, (start_inc == 2'd2)};
				end else if (phase_q == i2cseq_pkg::PH_ADDR) begin
					res.tx_byte = tgt_reg_q;
				end else begin
					res.tx_byte = rd_data;
				end
			end
			i2cseq_pkg::ACT_STORE, i2cseq_pkg::ACT_STORE_LAST: begin
				res.rx_index = position_q[4:0];
				res.rx_byte  = evt.data_byte;
			end
			default: begin
				res.tx_byte = 8'd0;
			end
		endcase
	end

	assign wr.en   = en && (evt.cmd == i2cseq_pkg::CMD_LOAD) &&
	                 (32'(evt.load_index) < i2cseq_pkg::MAX_LEN);
	assign wr.idx  = i2cseq_pkg::BUF_AW'(evt.load_index);
	assign wr.data = evt.data_byte;
	assign rd_idx  = en ? position_d[i2cseq_pkg::BUF_AW-1:0]
	                    : position_q[i2cseq_pkg::BUF_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cseq_pkg::PH_ADDR;
			write_mode_q <= 1'b0;
			tx_dir_q     <= 1'b0;
			start_cnt_q  <= 2'd0;
			position_q   <= 6'd0;
			byte_cnt_q   <= 6'd0;
			tgt_addr_q   <= 7'd0;
			tgt_reg_q    <= 8'd0;
			bus_held_q   <= 1'b0;
			nack_q       <= 1'b0;
		end else if (en) begin
			phase_q      <= phase_d;
			write_mode_q <= write_mode_d;
			tx_dir_q     <= tx_dir_d;
			start_cnt_q  <= start_cnt_d;
			position_q   <= position_d;
			byte_cnt_q   <= byte_cnt_d;
			tgt_addr_q   <= tgt_addr_d;
			tgt_reg_q    <= tgt_reg_d;
			bus_held_q   <= bus_held_d;
			nack_q       <= nack_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/i2c_register_transaction_sequencer.sv
// An accepted event waits in the input register until its result enters the output register.
// Throughput: one event per cycle while results are taken; the single decision stage sets the rate.
// The input register refills while a finished result waits in the output register.
// Reset clears all control state and the transaction registers.
// The write byte buffer is not cleared; entries hold nothing until loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2c_register_transaction_sequencer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              evt_valid,
	output logic                   evt_ready,
	input  wire i2cseq_pkg::evt_t  evt,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output i2cseq_pkg::res_t       res
);

	logic                             valid_s1;
	i2cseq_pkg::evt_t                 evt_s1;
	logic                             res_valid_q;
	i2cseq_pkg::res_t                 res_q;
	logic                             advance;
	i2cseq_pkg::res_t                 core_res;
	i2cseq_pkg::wbuf_wr_t             wr;
	logic [i2cseq_pkg::BUF_AW-1:0]    rd_idx;
	logic [7:0]                       rd_data;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt_valid && evt_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
		if (advance) begin
			res_q <= core_res;
		end
	end

	i2cseq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.evt     (evt_s1),
		.rd_data (rd_data),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.res     (core_res)
	);

	i2cseq_wbuf u_wbuf (
		.clk     (clk),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_IMPLIES(a_free_out_takes_evt, clk, arst_n, !res_valid_q, evt_ready)
	`ASSERT_IMPLIES(a_done_releases, clk, arst_n, res_valid_q && (res_q.action == i2cseq_pkg::ACT_DONE), !res_q.busy_res && !res_q.set_nack)
	`ASSERT_IMPLIES(a_begin_holds, clk, arst_n, res_valid_q && (res_q.action == i2cseq_pkg::ACT_BEGIN), res_q.busy_res && !res_q.set_nack)
	`ASSERT_IMPLIES(a_end_releases, clk, arst_n, res_valid_q && ((res_q.action == i2cseq_pkg::ACT_STOP) || (res_q.action == i2cseq_pkg::ACT_STORE_LAST)), !res_q.busy_res)

endmodule

`default_nettype wire

// File: test/i2c_action_checker.sv
// Checker for the I2C register transaction sequencer: predicts each action and compares it.
`timescale 1ns / 1ps

module i2c_action_checker
	import i2cseq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	input  logic evt_ready,
	input  evt_t evt,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   mismatches,
	output int   pending
);

	phase_t      ph = PH_ADDR;
	logic        wr_txn = 1'b0;
	logic        sending = 1'b0;
	logic        holding = 1'b0;
	logic        nack = 1'b0;
	logic [1:0]  starts = 2'd0;
	int unsigned pos = 0;
	int unsigned nbytes = 0;
	logic [6:0]  tgt_addr = 7'd0;
	logic [7:0]  tgt_reg = 8'd0;
	logic [7:0]  wbuf [MAX_LEN];

	res_t        expected_actions [$];
	res_t        want;
	int          fails = 0;

	function automatic action_t transfer_action(input logic ack, input logic [7:0] rx,
			inout res_t r);
		if (sending) begin
			if (!ack) begin
				holding = 1'b0;
				return ACT_STOP;
			end
			if (!wr_txn) begin
				case (ph)
					PH_ADDR: begin
						ph = PH_REG;
						r.tx_byte = tgt_reg;
						return ACT_SEND;
					end
					PH_REG: begin
						ph = PH_RXSTART;
						return ACT_RSTART;
					end
					PH_RXSTART: begin
						ph = PH_DATA;
						sending = 1'b0;
						if (nbytes == 1)
							nack = 1'b1;
						return ACT_TO_RX;
					end
					default: return ACT_NONE;
				endcase
			end
			if (ph == PH_ADDR) begin
				ph = PH_DATA;
				r.tx_byte = tgt_reg;
				return ACT_SEND;
			end
			if (ph == PH_DATA) begin
				if (pos >= nbytes || pos >= MAX_LEN) begin
					holding = 1'b0;
					return ACT_STOP;
				end
				r.tx_byte = wbuf[pos];
				pos++;
				return ACT_SEND;
			end
			return ACT_NONE;
		end
		if (ph != PH_DATA)
			return ACT_NONE;
		r.rx_index = 5'(pos);
		r.rx_byte = rx;
		if (pos + 1 >= nbytes) begin
			holding = 1'b0;
			return ACT_STORE_LAST;
		end
		if (pos + 2 == nbytes)
			nack = 1'b1;
		pos++;
		return ACT_STORE;
	endfunction

	function automatic res_t predict_action(input evt_t e);
		res_t    r;
		action_t act;
		r = '0;
		act = ACT_NONE;
		case (e.cmd)
			CMD_LOAD: wbuf[e.load_index] = e.data_byte;
			CMD_BEGIN_RD, CMD_BEGIN_WR: begin
				if (e.bus_busy || holding || e.length == 0 || e.length > MAX_LEN) begin
					act = ACT_REFUSED;
				end else begin
					tgt_addr = e.slave_address;
					tgt_reg = e.register_address;
					nbytes = e.length;
					wr_txn = (e.cmd == CMD_BEGIN_WR);
					ph = PH_ADDR;
					pos = 0;
					starts = 2'd0;
					sending = 1'b1;
					nack = 1'b0;
					holding = 1'b1;
					act = ACT_BEGIN;
				end
			end
			CMD_START: begin
				if (holding) begin
					if (starts != 2'd3)
						starts = starts + 2'd1;
					if (starts == 2'd1) begin
						r.tx_byte = {tgt_addr, 1'b0};
						act = ACT_SEND;
					end else if (starts == 2'd2) begin
						r.tx_byte = {tgt_addr, 1'b1};
						act = ACT_SEND;
					end else begin
						act = transfer_action(e.ack_received, e.data_byte, r);
					end
				end
			end
			CMD_XFER: begin
				if (holding)
					act = transfer_action(e.ack_received, e.data_byte, r);
			end
			CMD_STOP: begin
				nack = 1'b0;
				holding = 1'b0;
				act = ACT_DONE;
			end
			default: act = ACT_NONE;
		endcase
		r.action = act;
		r.set_nack = nack;
		r.busy_res = holding;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			fails++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_actions.size() == 0) begin
					fails++;
					$display("%0t: action expected none, got 0x%0h", $time, res.action);
				end else begin
					want = expected_actions.pop_front();
					check_field("action", 8'(want.action), 8'(res.action));
					check_field("tx_byte", want.tx_byte, res.tx_byte);
					check_field("set_nack", 8'(want.set_nack), 8'(res.set_nack));
					check_field("rx_index", 8'(want.rx_index), 8'(res.rx_index));
					check_field("rx_byte", want.rx_byte, res.rx_byte);
					check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
				end
			end
			if (evt_valid && evt_ready)
				expected_actions.push_back(predict_action(evt));
			mismatches <= fails;
			pending <= expected_actions.size();
		end
	end

endmodule

// File: test/testbench.sv
// Top of the sequencer testbench: clock, reset, bus event stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import i2cseq_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int HOLD_OFF_AT     = 200;
	localparam int CALM_AFTER      = 450;
	localparam int ITEM_TARGET     = 550;
	localparam int DRAIN_CYCLES    = 8;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	evt_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	int   mismatches;
	int   pending;
	int   items_sent = 0;
	bit   idling_on = 1'b1;
	bit   hold_off_req = 1'b0;
	bit   hold_done = 1'b0;
	bit   loaded [MAX_LEN];

	i2c_register_transaction_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	i2c_action_checker action_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((evt_valid && evt_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[i2c_register_transaction_sequencer] ERROR");
		$finish;
	end

	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				res_ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic evt_t rand_evt(input logic [2:0] code);
		evt_t e;
		e.cmd = cmd_t'(code);
		e.slave_address = 7'($urandom_range(0, 127));
		e.register_address = 8'($urandom_range(0, 255));
		e.length = 6'($urandom_range(0, 63));
		e.data_byte = 8'($urandom_range(0, 255));
		e.load_index = 5'($urandom_range(0, 31));
		e.ack_received = 1'($urandom_range(0, 1));
		e.bus_busy = 1'($urandom_range(0, 1));
		return e;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 4);
		if (r < 19)
			return $urandom_range(5, 16);
		return $urandom_range(17, 32);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer(input evt_t e);
		if (idling_on && !hold_off_req && $urandom_range(0, 4) == 0) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		if (e.cmd == CMD_LOAD)
			loaded[e.load_index] = 1'b1;
		items_sent++;
		do @(posedge clk); while (!evt_ready);
		@(negedge clk);
	endtask

	task automatic bus_event(input logic [2:0] code, input logic ack);
		evt_t e;
		e = rand_evt(code);
		e.ack_received = ack;
		offer(e);
	endtask

	task automatic acked_event(input logic [2:0] code, input bit faults, output bit dropped);
		logic ack;
		ack = !(faults && $urandom_range(0, 15) == 0);
		bus_event(code, ack);
		dropped = !ack;
	endtask

	task automatic read_txn(input logic [6:0] sa, input logic [7:0] ra, input int len,
			input bit faults);
		evt_t e;
		bit   dropped;
		e = rand_evt(CMD_BEGIN_RD);
		e.slave_address = sa;
		e.register_address = ra;
		e.length = 6'(len);
		e.bus_busy = 1'b0;
		offer(e);
		if (faults && $urandom_range(0, 7) == 0)
			offer(rand_evt($urandom_range(0, 1) ? CMD_BEGIN_RD : CMD_BEGIN_WR));
		bus_event(CMD_START, 1'b1);
		acked_event(CMD_XFER, faults, dropped);
		if (!dropped)
			acked_event(CMD_XFER, faults, dropped);
		if (!dropped) begin
			bus_event(CMD_START, 1'b1);
			acked_event(CMD_XFER, faults, dropped);
		end
		if (!dropped) begin
			// a third start counts as a received byte
			for (int i = 0; i < len; i++)
				bus_event((faults && $urandom_range(0, 7) == 0) ? CMD_START : CMD_XFER,
					1'($urandom_range(0, 1)));
		end
		bus_event(CMD_STOP, 1'($urandom_range(0, 1)));
	endtask

	task automatic write_txn(input logic [6:0] sa, input logic [7:0] ra, input int len,
			input bit faults);
		evt_t e;
		bit   dropped;
		for (int i = 0; i < len; i++) begin
			e = rand_evt(CMD_LOAD);
			e.load_index = 5'(i);
			offer(e);
		end
		e = rand_evt(CMD_BEGIN_WR);
		e.slave_address = sa;
		e.register_address = ra;
		e.length = 6'(len);
		e.bus_busy = 1'b0;
		offer(e);
		bus_event(CMD_START, 1'b1);
		dropped = 1'b0;
		// register byte, data bytes, then the transfer that ends in stop
		for (int i = 0; i <= len + 1 && !dropped; i++)
			acked_event(CMD_XFER, faults, dropped);
		bus_event(CMD_STOP, 1'($urandom_range(0, 1)));
	endtask

	task automatic noise_burst();
		evt_t e;
		int   n;
		repeat ($urandom_range(1, 4)) begin
			e = rand_evt(3'($urandom_range(0, 7)));
			if (e.cmd == CMD_BEGIN_WR && e.length != 0 && e.length <= MAX_LEN) begin
				n = 0;
				while (n < MAX_LEN && loaded[n])
					n++;
				// never let a write reach an empty buffer entry
				if (e.length > n)
					e.cmd = CMD_BEGIN_RD;
			end
			offer(e);
		end
		bus_event(CMD_STOP, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		evt_t e;
		int   sel;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		bus_event(CMD_XFER, 1'b1);
		bus_event(CMD_START, 1'b1);
		bus_event(CMD_UNUSED_LO, 1'b1);
		bus_event(CMD_UNUSED_HI, 1'b1);
		e = rand_evt(CMD_BEGIN_RD);
		e.bus_busy = 1'b0;
		e.length = 6'd0;
		offer(e);
		e.length = 6'd33;
		offer(e);
		e.length = 6'd8;
		e.bus_busy = 1'b1;
		offer(e);
		e = rand_evt(CMD_LOAD);
		e.load_index = 5'd31;
		e.data_byte = 8'h00;
		offer(e);
		read_txn(7'h7F, 8'hFF, 1, 1'b0);
		write_txn(7'h00, 8'h00, 1, 1'b0);
		e = rand_evt(CMD_BEGIN_RD);
		e.bus_busy = 1'b0;
		e.length = 6'd32;
		offer(e);
		bus_event(CMD_START, 1'b1);
		bus_event(CMD_XFER, 1'b0);
		bus_event(CMD_STOP, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent >= HOLD_OFF_AT) begin
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			if (items_sent >= CALM_AFTER)
				idling_on = 1'b0;
			sel = $urandom_range(0, 9);
			if (sel < 4)
				read_txn(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), pick_len(),
					1'b1);
			else if (sel < 7)
				write_txn(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), pick_len(),
					1'b1);
			else
				noise_burst();
		end
		evt_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[i2c_register_transaction_sequencer] OK");
		else
			$display("[i2c_register_transaction_sequencer] ERROR");
		$finish;
	end

endmodule
